// ----- sv/tbac_pkg.sv -----
// package for the text box agglomerative clusterer
// holds the sequencer state type and fixed constants; no dependencies
package tbac_pkg;
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN_RD,
		ST_SCAN_WAIT,
		ST_SCAN_CALC,
		ST_DECIDE,
		ST_MERGE_RD,
		ST_MERGE_WAIT,
		ST_MERGE_WR,
		ST_RELABEL_RD,
		ST_RELABEL_WAIT,
		ST_RELABEL_WR,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_HOLD
	} tbac_state_t;

	localparam int unsigned VScaleSq = 9;
	localparam logic [13:0] MaxDistReset = 14'd10000;
endpackage

// ----- sv/tbac_ram.sv -----
// generic single write port, two read port synchronous ram
// registered read data; no dependencies
module tbac_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

// ----- sv/text_box_agglomerative_clusterer.sv -----
// top level of the text box agglomerative clusterer
// uses tbac_pkg and tbac_ram for cluster and box stores
//
// usage:
// boxes arrive on the input channel (box_x .. box_height, last_box), one per
// transfer; boxes beyond MAX_BOXES are dropped. the transfer with last_box
// high starts clustering: the sequencer scans all cluster pairs (one read of
// the cluster ram each), merges the closest pair when its squared distance
// is within the threshold squared, compacts the cluster ram and relabels
// every box, then scans again.
// results (box_index, group_id, last_result) follow one per box in load
// order, held while the receiver stalls.
// the threshold is written on the cfg channel; the user must write it only while the block is idle (not enforced).
// reset clears the counters and the sequencer; the rams are not cleared,
// since only written entries are ever read.
module text_box_agglomerative_clusterer #(
	parameter int unsigned MAX_BOXES  = 64,
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [13:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] box_x,
	input  logic [COORD_BITS-1:0] box_y,
	input  logic [COORD_BITS-1:0] box_width,
	input  logic [COORD_BITS-1:0] box_height,
	input  logic                  last_box,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [5:0]            box_index,
	output logic [6:0]            group_id,
	output logic                  last_result
);
	import tbac_pkg::*;

	localparam int unsigned AW = $clog2(MAX_BOXES);
	localparam int unsigned CW = $clog2(MAX_BOXES + 1);
	localparam int unsigned PW = COORD_BITS + 1;
	// cluster record: lx, lc, rx, rc, lo, hi
	localparam int unsigned RW = 2 * COORD_BITS + 4 * PW;
	localparam int unsigned DW = 2 * PW + 4;

	typedef struct packed {
		logic [COORD_BITS-1:0] lx;
		logic [PW-1:0]         lc;
		logic [COORD_BITS-1:0] rx;
		logic [PW-1:0]         rc;
		logic [PW-1:0]         lo;
		logic [PW-1:0]         hi;
	} rec_t;

	tbac_state_t state_q, state_d;

	logic [13:0]   max_dist_q;
	logic [CW-1:0] box_cnt_q, clu_cnt_q;
	logic [AW-1:0] i_q, j_q, bi_q, bj_q, s_q, d_q, b_q;
	logic          found_q;
	logic [DW-1:0] best_q, dist_q;
	rec_t          mrg_q;

	// cluster ram
	logic          c_we;
	logic [AW-1:0] c_waddr, c_ra, c_rb;
	rec_t          c_wdata, c_qa, c_qb;
	// box slot ram
	logic          s_we;
	logic [AW-1:0] s_waddr, s_ra;
	logic [AW-1:0] s_wdata, s_qa, s_qb_unused;

	tbac_ram #(.WIDTH(RW), .DEPTH(MAX_BOXES)) u_clu_ram (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr_a(c_ra), .rdata_a(c_qa), .raddr_b(c_rb), .rdata_b(c_qb)
	);
	tbac_ram #(.WIDTH(AW), .DEPTH(MAX_BOXES)) u_slot_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr_a(s_ra), .rdata_a(s_qa), .raddr_b(s_ra), .rdata_b(s_qb_unused)
	);

	// pair distance from the two registered reads
	function automatic logic [PW-1:0] adiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		adiff = (a > b) ? a - b : b - a;
	endfunction

	logic [PW-1:0] h_gap, v_gap, h1, h2, v1, v2;
	logic [DW-1:0] dist_sq, limit;
	always_comb begin
		h1 = adiff(c_qa.lc, c_qb.rc);
		h2 = adiff(c_qb.lc, c_qa.rc);
		v1 = adiff(c_qa.lo, c_qb.hi);
		v2 = adiff(c_qb.lo, c_qa.hi);
		h_gap = (h1 < h2) ? h1 : h2;
		v_gap = (v1 < v2) ? v1 : v2;
		dist_sq = DW'(h_gap) * DW'(h_gap) + DW'(VScaleSq) * DW'(v_gap) * DW'(v_gap);
		limit = DW'(max_dist_q) * DW'(max_dist_q);
	end

	logic load_fire, full;
	assign full      = (box_cnt_q == CW'(MAX_BOXES));
	assign load_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// slot under compaction survives the merge
	logic tail_kept;
	assign tail_kept = !(s_q == bi_q || s_q == bj_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (load_fire && last_box) state_d = ST_SCAN_RD;
			ST_SCAN_RD: begin
				if (clu_cnt_q < CW'(2)) state_d = ST_DECIDE;
				else state_d = ST_SCAN_WAIT;
			end
			ST_SCAN_WAIT: state_d = ST_SCAN_CALC;
			ST_SCAN_CALC: begin
				if (CW'(j_q) + 1'b1 < clu_cnt_q || CW'(i_q) + CW'(2) < clu_cnt_q)
					state_d = ST_SCAN_RD;
				else state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (found_q && best_q <= limit) state_d = ST_MERGE_RD;
				else if (box_cnt_q == '0) state_d = ST_LOAD;
				else state_d = ST_OUT_RD;
			end
			ST_MERGE_RD:   state_d = ST_MERGE_WAIT;
			ST_MERGE_WAIT: state_d = ST_MERGE_WR;
			ST_MERGE_WR: begin
				if (CW'(s_q) + 1'b1 < clu_cnt_q) state_d = ST_MERGE_RD;
				else state_d = ST_RELABEL_RD;
			end
			ST_RELABEL_RD:   state_d = ST_RELABEL_WAIT;
			ST_RELABEL_WAIT: state_d = ST_RELABEL_WR;
			ST_RELABEL_WR: begin
				if (CW'(b_q) + 1'b1 < box_cnt_q) state_d = ST_RELABEL_RD;
				else state_d = ST_SCAN_RD;
			end
			ST_OUT_RD:   state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				if (out_ready) begin
					if (CW'(b_q) + 1'b1 < box_cnt_q) state_d = ST_OUT_RD;
					else state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// memory control and handshake outputs
	rec_t load_rec;
	always_comb begin
		load_rec.lx = box_x;
		load_rec.rx = box_x;
		load_rec.lc = PW'(box_x) + PW'(box_width >> 1);
		load_rec.rc = load_rec.lc;
		load_rec.lo = PW'(box_y) + PW'(box_height);
		load_rec.hi = load_rec.lo;

		in_ready  = (state_q == ST_LOAD);
		out_valid = (state_q == ST_OUT_HOLD);
		c_we = 1'b0; c_waddr = box_cnt_q[AW-1:0]; c_wdata = load_rec;
		s_we = 1'b0; s_waddr = box_cnt_q[AW-1:0]; s_wdata = box_cnt_q[AW-1:0];
		c_ra = i_q; c_rb = j_q; s_ra = b_q;
		case (state_q)
			ST_LOAD: begin
				c_we = load_fire && !full;
				s_we = load_fire && !full;
			end
			// fetch the chosen pair, ready at the first merge read
			ST_DECIDE: begin
				c_ra = bi_q;
				c_rb = bj_q;
			end
			ST_MERGE_RD, ST_MERGE_WAIT: c_ra = s_q;
			ST_MERGE_WR: begin
				// kept slots move down, the merged pair is skipped
				c_we = tail_kept;
				c_waddr = d_q;
				c_wdata = c_qa;
			end
			ST_RELABEL_RD: begin
				// merged record lands in the new last slot
				c_we = 1'b1;
				c_waddr = AW'(clu_cnt_q - CW'(1));
				c_wdata = mrg_q;
			end
			ST_RELABEL_WR: begin
				s_we = 1'b1;
				s_waddr = b_q;
				if (s_qa == bi_q || s_qa == bj_q) s_wdata = AW'(clu_cnt_q - CW'(1));
				else if (s_qa > bj_q) s_wdata = s_qa - AW'(2);
				else if (s_qa > bi_q) s_wdata = s_qa - AW'(1);
				else s_wdata = s_qa;
			end
			default: ;
		endcase
	end

	assign box_index   = 6'(b_q);
	assign group_id    = 7'(s_qa) + 7'd1;
	assign last_result = (CW'(b_q) + 1'b1 == box_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			max_dist_q <= MaxDistReset;
			box_cnt_q  <= '0;
			clu_cnt_q  <= '0;
			i_q <= '0; j_q <= '0; bi_q <= '0; bj_q <= '0;
			s_q <= '0; d_q <= '0; b_q <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			dist_q  <= '0;
			mrg_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) max_dist_q <= cfg_data;
			case (state_q)
				ST_LOAD: begin
					if (load_fire && !full) begin
						box_cnt_q <= box_cnt_q + 1'b1;
						clu_cnt_q <= box_cnt_q + 1'b1;
					end
					i_q <= '0; j_q <= AW'(1); found_q <= 1'b0;
				end
				ST_SCAN_WAIT: dist_q <= dist_sq;
				ST_SCAN_CALC: begin
					if (!found_q || dist_q < best_q) begin
						found_q <= 1'b1; best_q <= dist_q;
						bi_q <= i_q; bj_q <= j_q;
					end
					if (CW'(j_q) + 1'b1 < clu_cnt_q) j_q <= j_q + 1'b1;
					else begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + AW'(2);
					end
				end
				ST_DECIDE: begin
					i_q <= bi_q; j_q <= bj_q;
					s_q <= '0; d_q <= '0; b_q <= '0;
				end
				ST_MERGE_RD: begin
					// pair records read in the decide cycle are on the ports now
					if (s_q == '0) begin
						mrg_q.lx <= (c_qa.lx <= c_qb.lx) ? c_qa.lx : c_qb.lx;
						mrg_q.lc <= (c_qa.lx <= c_qb.lx) ? c_qa.lc : c_qb.lc;
						mrg_q.rx <= (c_qa.rx >= c_qb.rx) ? c_qa.rx : c_qb.rx;
						mrg_q.rc <= (c_qa.rx >= c_qb.rx) ? c_qa.rc : c_qb.rc;
						mrg_q.lo <= (c_qa.lo < c_qb.lo) ? c_qa.lo : c_qb.lo;
						mrg_q.hi <= (c_qa.hi > c_qb.hi) ? c_qa.hi : c_qb.hi;
					end
				end
				ST_MERGE_WR: begin
					if (CW'(s_q) + 1'b1 < clu_cnt_q) begin
						s_q <= s_q + 1'b1;
						if (tail_kept) d_q <= d_q + 1'b1;
					end else begin
						clu_cnt_q <= clu_cnt_q - 1'b1;
						b_q <= '0;
					end
				end
				ST_RELABEL_WR: begin
					if (CW'(b_q) + 1'b1 < box_cnt_q) b_q <= b_q + 1'b1;
					else begin
						i_q <= '0; j_q <= AW'(1); found_q <= 1'b0;
					end
				end
				ST_OUT_HOLD: begin
					if (out_ready) begin
						if (CW'(b_q) + 1'b1 < box_cnt_q) b_q <= b_q + 1'b1;
						else begin
							box_cnt_q <= '0;
							clu_cnt_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		clu_cnt_q <= box_cnt_q) else $error("cluster count above box count");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		box_cnt_q <= CW'(MAX_BOXES)) else $error("box count above capacity");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE_RD |-> bi_q < bj_q) else $error("merge pair out of order");
	a_merge_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE_WR && state_d == ST_RELABEL_RD |=> clu_cnt_q == $past(clu_cnt_q) - 1'b1)
		else $error("merge did not drop one cluster");
`endif
endmodule
